// ===== src/sfd_pkg.sv =====
// Shared constants and types for the sensor frame deframer.
// No dependencies; used by every module in src.
package sfd_pkg;

    localparam int MAX_CHANNEL_COUNT = 32;

    // Widths that follow from the channel limit.
    localparam int CH_IDX_W = (MAX_CHANNEL_COUNT > 1) ? $clog2(MAX_CHANNEL_COUNT) : 1;
    localparam int EXP_W    = $clog2(MAX_CHANNEL_COUNT + 1);
    localparam int CNT_W    = $clog2(4 * MAX_CHANNEL_COUNT + 1);

    // Fixed field widths.
    localparam int BYTE_W   = 8;
    localparam int SEQ_W    = 16;
    localparam int IDX_W    = 5;
    localparam int COUNT_W  = 6;
    localparam int WORD_W   = 32;
    localparam int FIELDS_W = SEQ_W + IDX_W + COUNT_W + WORD_W;
    localparam int TDATA_W  = ((FIELDS_W + 7) / 8) * 8;
    localparam int PAD_W    = TDATA_W - FIELDS_W;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_HDR_FIRST  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_HDR_SECOND = 1'b1;
    localparam logic [BYTE_W-1:0] HDR_FIRST_RST  = 8'hAA;
    localparam logic [BYTE_W-1:0] HDR_SECOND_RST = 8'h55;

    // Command queue; depth is a power of two so the pointers wrap on their own.
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // Completed packet handed from front to back.
    typedef struct packed {
        logic [SEQ_W-1:0] seq;
        logic [EXP_W-1:0] n;
    } t_cmd;

    // Channel word store write.
    typedef struct packed {
        logic                en;
        logic [CH_IDX_W-1:0] addr;
        logic [WORD_W-1:0]   data;
    } t_mem_wr;

endpackage

// ===== src/sfd_front.sv =====
// Front end: config registers, header hunt, length check, byte assembly.
// Depends on sfd_pkg. Writes channel words and pushes packet commands.
module sfd_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    input  logic [sfd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [sfd_pkg::BYTE_W-1:0]    i_cfg_data,
    input  logic                          i_s_valid,
    input  logic [sfd_pkg::BYTE_W-1:0]    i_s_byte,
    output logic                          o_s_ready,
    input  logic                          i_back_busy,
    input  logic                          i_cmd_full,
    output sfd_pkg::t_mem_wr              o_mem_wr,
    output logic                          o_cmd_push,
    output sfd_pkg::t_cmd                 o_cmd
);

    typedef enum logic [2:0] {
        PH_HUNT, PH_LEN_HI, PH_LEN_LO, PH_SEQ_HI, PH_SEQ_LO, PH_DATA, PH_TRAIL
    } t_phase;

    t_phase                        r_phase;
    logic                          r_saw;
    logic [sfd_pkg::BYTE_W-1:0]    r_hdr1;
    logic [sfd_pkg::BYTE_W-1:0]    r_hdr2;
    logic [sfd_pkg::BYTE_W-1:0]    r_len_hi;
    logic [sfd_pkg::SEQ_W-1:0]     r_seq;
    logic [sfd_pkg::EXP_W-1:0]     r_exp;
    logic [sfd_pkg::CNT_W-1:0]     r_cnt;
    logic [23:0]                   r_word;
    sfd_pkg::t_mem_wr              r_mem_wr;
    logic                          r_cmd_push;
    sfd_pkg::t_cmd                 r_cmd;

    logic                          accept;
    logic [15:0]                   len;
    logic                          len_ok;
    logic [sfd_pkg::CNT_W:0]       cnt_next;
    logic                          data_done;
    // bad-length resync: hunter refed with hdr2, len hi, len lo
    logic                          rs_saw1;
    logic                          rs_hit2;
    logic                          rs_saw2;
    t_phase                        rs_phase;
    logic                          rs_saw3;

    always_comb begin
        unique case (r_phase)
            PH_DATA:  o_s_ready = !i_back_busy;
            PH_TRAIL: o_s_ready = !i_cmd_full;
            default:  o_s_ready = 1'b1;
        endcase
    end

    assign accept    = i_s_valid && o_s_ready;
    assign len       = {r_len_hi, i_s_byte};
    assign len_ok    = (len[1:0] == 2'b11) && (len[15:2] <= 14'(sfd_pkg::MAX_CHANNEL_COUNT));
    assign cnt_next  = {1'b0, r_cnt} + 1'b1;
    assign data_done = cnt_next >= ((sfd_pkg::CNT_W+1)'(r_exp) << 2);

    always_comb begin
        rs_saw1 = (r_hdr2 == r_hdr1);
        rs_hit2 = rs_saw1 && (r_len_hi == r_hdr2);
        rs_saw2 = !rs_hit2 && (r_len_hi == r_hdr1);
        if (rs_hit2) begin
            rs_phase = PH_LEN_LO;
            rs_saw3  = 1'b0;
        end else if (rs_saw2 && (i_s_byte == r_hdr2)) begin
            rs_phase = PH_LEN_HI;
            rs_saw3  = 1'b0;
        end else begin
            rs_phase = PH_HUNT;
            rs_saw3  = (i_s_byte == r_hdr1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HUNT;
            r_saw       <= 1'b0;
            r_hdr1      <= sfd_pkg::HDR_FIRST_RST;
            r_hdr2      <= sfd_pkg::HDR_SECOND_RST;
            r_cnt       <= '0;
            r_exp       <= '0;
            r_mem_wr.en <= 1'b0;
            r_cmd_push  <= 1'b0;
        end else begin
            r_mem_wr.en <= 1'b0;
            r_cmd_push  <= 1'b0;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    sfd_pkg::REG_HDR_FIRST:  r_hdr1 <= i_cfg_data;
                    sfd_pkg::REG_HDR_SECOND: r_hdr2 <= i_cfg_data;
                    default: ;
                endcase
            end
            if (accept) begin
                unique case (r_phase)
                    PH_HUNT: begin
                        if (r_saw && i_s_byte == r_hdr2) begin
                            r_phase <= PH_LEN_HI;
                            r_saw   <= 1'b0;
                        end else begin
                            r_saw <= (i_s_byte == r_hdr1);
                        end
                    end
                    PH_LEN_HI: begin
                        r_len_hi <= i_s_byte;
                        r_phase  <= PH_LEN_LO;
                    end
                    PH_LEN_LO: begin
                        if (len_ok) begin
                            r_exp   <= sfd_pkg::EXP_W'(len[15:2]);
                            r_cnt   <= '0;
                            r_phase <= PH_SEQ_HI;
                        end else begin
                            r_phase <= rs_phase;
                            r_saw   <= rs_saw3;
                            if (rs_hit2) begin
                                r_len_hi <= i_s_byte;
                            end
                        end
                    end
                    PH_SEQ_HI: begin
                        r_seq[15:8] <= i_s_byte;
                        r_phase     <= PH_SEQ_LO;
                    end
                    PH_SEQ_LO: begin
                        r_seq[7:0] <= i_s_byte;
                        r_phase    <= (r_exp == '0) ? PH_TRAIL : PH_DATA;
                    end
                    PH_DATA: begin
                        unique case (r_cnt[1:0])
                            2'd0: r_word <= {16'h0000, i_s_byte};
                            2'd1: r_word[15:8] <= i_s_byte;
                            2'd2: r_word[23:16] <= i_s_byte;
                            default: begin
                                r_mem_wr.en   <= 1'b1;
                                r_mem_wr.addr <= r_cnt[2 +: sfd_pkg::CH_IDX_W];
                                r_mem_wr.data <= {i_s_byte, r_word};
                            end
                        endcase
                        if (data_done) begin
                            r_phase <= PH_TRAIL;
                            r_cnt   <= '0;
                        end else begin
                            r_cnt <= cnt_next[sfd_pkg::CNT_W-1:0];
                        end
                    end
                    default: begin
                        // trailing byte is dropped; packet is complete
                        r_cmd_push <= 1'b1;
                        r_cmd.seq  <= r_seq;
                        r_cmd.n    <= r_exp;
                        r_phase    <= PH_HUNT;
                        r_saw      <= 1'b0;
                        r_cnt      <= '0;
                    end
                endcase
            end
        end
    end

    assign o_mem_wr   = r_mem_wr;
    assign o_cmd_push = r_cmd_push;
    assign o_cmd      = r_cmd;

endmodule

// ===== src/sfd_cmd_fifo.sv =====
// Two-entry queue of completed packet commands between front and back.
// Depends on sfd_pkg.
module sfd_cmd_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  sfd_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output logic          o_valid,
    output logic          o_full,
    output sfd_pkg::t_cmd o_cmd
);

    sfd_pkg::t_cmd                  r_mem [sfd_pkg::FIFO_DEPTH];
    logic [sfd_pkg::FIFO_PTR_W-1:0] r_wptr;
    logic [sfd_pkg::FIFO_PTR_W-1:0] r_rptr;
    logic [sfd_pkg::FIFO_CNT_W-1:0] r_count;
    logic                           do_push;
    logic                           do_pop;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == sfd_pkg::FIFO_CNT_W'(sfd_pkg::FIFO_DEPTH));
    assign o_cmd   = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            r_count <= r_count + sfd_pkg::FIFO_CNT_W'(do_push)
                               - sfd_pkg::FIFO_CNT_W'(do_pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("command pushed into full queue");

endmodule

// ===== src/sfd_back.sv =====
// Back end: channel word store and result sequencer into the output register.
// Depends on sfd_pkg; fed by sfd_front and sfd_cmd_fifo.
module sfd_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  sfd_pkg::t_mem_wr                i_mem_wr,
    input  logic                            i_cmd_valid,
    input  sfd_pkg::t_cmd                   i_cmd,
    output logic                            o_cmd_pop,
    output logic                            o_busy,
    input  logic                            i_m_ready,
    output logic                            o_m_valid,
    output logic                            o_m_last,
    output logic [sfd_pkg::SEQ_W-1:0]       o_seq,
    output logic [sfd_pkg::IDX_W-1:0]       o_idx,
    output logic [sfd_pkg::COUNT_W-1:0]     o_count,
    output logic [sfd_pkg::WORD_W-1:0]      o_bits
);

    logic [sfd_pkg::WORD_W-1:0]   r_mem [sfd_pkg::MAX_CHANNEL_COUNT];
    logic                         r_active;
    logic [sfd_pkg::CH_IDX_W-1:0] r_k;
    logic [sfd_pkg::EXP_W-1:0]    r_n;
    logic [sfd_pkg::SEQ_W-1:0]    r_seq;
    logic                         r_out_valid;
    logic                         r_out_last;

    logic                         load_en;
    logic                         k_last;
    logic                         empty_pkt;

    assign load_en   = !r_out_valid || i_m_ready;
    assign k_last    = (sfd_pkg::EXP_W'(r_k) + 1'b1) == r_n;
    assign o_cmd_pop = load_en && !r_active && i_cmd_valid;
    assign empty_pkt = (i_cmd.n == '0);
    assign o_busy    = r_active || i_cmd_valid;

    // store and payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (i_mem_wr.en) begin
            r_mem[i_mem_wr.addr] <= i_mem_wr.data;
        end
        if (load_en && r_active) begin
            o_bits  <= r_mem[r_k];
            o_seq   <= r_seq;
            o_idx   <= sfd_pkg::IDX_W'(r_k);
            o_count <= sfd_pkg::COUNT_W'(r_n);
        end else if (o_cmd_pop && empty_pkt) begin
            o_bits  <= '0;
            o_seq   <= i_cmd.seq;
            o_idx   <= '0;
            o_count <= '0;
        end
        if (o_cmd_pop) begin
            r_seq <= i_cmd.seq;
            r_n   <= i_cmd.n;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
            r_out_last  <= 1'b0;
        end else if (load_en) begin
            if (r_active) begin
                r_out_valid <= 1'b1;
                r_out_last  <= k_last;
                if (k_last) begin
                    r_active <= 1'b0;
                end else begin
                    r_k <= r_k + 1'b1;
                end
            end else if (i_cmd_valid) begin
                r_k <= '0;
                if (empty_pkt) begin
                    r_out_valid <= 1'b1;
                    r_out_last  <= 1'b1;
                end else begin
                    r_active    <= 1'b1;
                    r_out_valid <= 1'b0;
                end
            end else begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_m_valid = r_out_valid;
    assign o_m_last  = r_out_last;

    a_k_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (sfd_pkg::EXP_W'(r_k) < r_n))
        else $error("channel index past packet count");

    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_last) |-> !r_active)
        else $error("last result shown while run still active");

    a_stall_holds_k: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_ready) |=> $stable(r_k))
        else $error("channel index moved during output stall");

endmodule

// ===== src/sensor_frame_deframer.sv =====
// Top level of the sensor frame deframer: front parser, command queue, back sequencer.
// Depends on sfd_pkg, sfd_front, sfd_cmd_fifo, sfd_back.
//
// Channel   Dir  Handshake                      Payload
// s_axis    in   s_axis_tvalid/s_axis_tready    tdata[7:0] rx_byte
// m_axis    out  m_axis_tvalid/m_axis_tready    tdata: seq, index, count, bits; tlast
// cfg       in   i_cfg_valid/o_cfg_ready        i_cfg_index, i_cfg_data[7:0]
//
// One received byte is taken per cycle in the header, length and sequence phases.
// Channel data bytes are held off while the back end still holds an earlier packet
// (queued or draining) from the shared 32-entry word store; the trailing byte waits
// for a free slot in the two-entry command queue.
// A command is registered in the front end after its trailing byte, then written into the queue. An empty
// packet's result is loaded as the command is taken; otherwise results start in the cycle
// after the take, one per cycle while the receiver is ready, from the store's registered read port.
// Reset (synchronous, active low) returns to header hunt with default header bytes.
// The config port is always ready; writes take effect on the next byte.
module sensor_frame_deframer (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // config write channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [sfd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [sfd_pkg::BYTE_W-1:0]      i_cfg_data,
    // byte input stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [sfd_pkg::BYTE_W-1:0]      s_axis_tdata,   // [7:0] rx_byte
    // result stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [15:0] sequence_number, [20:16] channel_index, [26:21] channel_count,
    // [58:27] channel_bits, [63:59] zero
    output logic [sfd_pkg::TDATA_W-1:0]     m_axis_tdata,
    output logic                            m_axis_tlast    // last_of_packet
);

    sfd_pkg::t_mem_wr                 mem_wr;
    sfd_pkg::t_cmd                    push_cmd;
    sfd_pkg::t_cmd                    head_cmd;
    logic                             cmd_push;
    logic                             cmd_pop;
    logic                             cmd_valid;
    logic                             cmd_full;
    logic                             back_busy;
    logic [sfd_pkg::SEQ_W-1:0]        out_seq;
    logic [sfd_pkg::IDX_W-1:0]        out_idx;
    logic [sfd_pkg::COUNT_W-1:0]      out_count;
    logic [sfd_pkg::WORD_W-1:0]       out_bits;

    assign o_cfg_ready = 1'b1;

    sfd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_valid   (s_axis_tvalid),
        .i_s_byte    (s_axis_tdata),
        .o_s_ready   (s_axis_tready),
        .i_back_busy (back_busy),
        .i_cmd_full  (cmd_full),
        .o_mem_wr    (mem_wr),
        .o_cmd_push  (cmd_push),
        .o_cmd       (push_cmd)
    );

    sfd_cmd_fifo u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_cmd   (push_cmd),
        .i_pop   (cmd_pop),
        .o_valid (cmd_valid),
        .o_full  (cmd_full),
        .o_cmd   (head_cmd)
    );

    sfd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mem_wr    (mem_wr),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (head_cmd),
        .o_cmd_pop   (cmd_pop),
        .o_busy      (back_busy),
        .i_m_ready   (m_axis_tready),
        .o_m_valid   (m_axis_tvalid),
        .o_m_last    (m_axis_tlast),
        .o_seq       (out_seq),
        .o_idx       (out_idx),
        .o_count     (out_count),
        .o_bits      (out_bits)
    );

    assign m_axis_tdata = {{sfd_pkg::PAD_W{1'b0}}, out_bits, out_count, out_idx, out_seq};

endmodule

// ===== tb/sensor_frame_deframer_test.sv =====
// Self-checking testbench for sensor_frame_deframer: byte stream in, channel results out.
// Uses sfd_pkg for port widths and register indexes; predicts results in-line, directed rows give typed ones.
`timescale 1ns / 100ps

module sensor_frame_deframer_test;

    localparam int HALF_PERIOD = 10;
    localparam int SETTLE_CYCLES = 40;   // back end drains at most 32 words, plus margin
    localparam int RANDOM_BYTES = 460;

    // Parser phases, same order as the block walks them.
    typedef enum logic [2:0] {
        PH_HUNT, PH_LEN_HI, PH_LEN_LO, PH_SEQ, PH_DATA, PH_TRAIL
    } t_parse_phase;

    // One expected result, field by field.
    typedef struct packed {
        logic [15:0] seq;
        logic [4:0]  idx;
        logic [5:0]  count;
        logic [31:0] bits;
        logic        last;
    } t_frame_result;

    // Directed row: one byte, and optionally the single result it completes.
    typedef struct packed {
        logic          has_want;
        logic [7:0]    rx;
        t_frame_result want;
    } t_directed_row;

    localparam t_frame_result NO_RESULT = '0;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_cfg_valid;
    logic                          o_cfg_ready;
    logic [sfd_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [sfd_pkg::BYTE_W-1:0]    i_cfg_data;
    logic                          s_axis_tvalid;
    logic                          s_axis_tready;
    logic [sfd_pkg::BYTE_W-1:0]    s_axis_tdata;    // [7:0] rx_byte
    logic                          m_axis_tvalid;
    logic                          m_axis_tready;
    // [15:0] sequence_number, [20:16] channel_index, [26:21] channel_count,
    // [58:27] channel_bits, [63:59] zero
    logic [sfd_pkg::TDATA_W-1:0]   m_axis_tdata;
    logic                          m_axis_tlast;    // last_of_packet

    sensor_frame_deframer i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // ------------------------------------------------------------------
    // Predictor state: a private copy of the parser and its header bytes
    // ------------------------------------------------------------------
    logic [7:0]   hdr_first;
    logic [7:0]   hdr_second;
    t_parse_phase hunt_phase;
    logic         seen_first;
    logic [15:0]  len_word;
    logic [7:0]   byte_pos;
    logic [15:0]  seq_word;
    logic [23:0]  word_acc;
    logic [31:0]  chan_words [sfd_pkg::MAX_CHANNEL_COUNT];
    logic [5:0]   chan_total;

    t_frame_result pending_results [$];

    int  mismatch_count = 0;
    int  results_seen = 0;
    int  bytes_sent = 0;
    int  packets_sent = 0;
    int  full_packets = 0;
    int  bad_lengths = 0;
    bit  calm = 1'b0;          // suppresses idling on both sides

    t_directed_row directed_tbl [0:26];

    // Header hunt and length capture. Returns 1 when the length is not 3 + 4k, k <= max.
    function automatic bit take_front(input logic [7:0] b);
        bit bad;
        int body;
        bad = 1'b0;
        case (hunt_phase)
            PH_HUNT: begin
                if (seen_first && b == hdr_second) begin
                    hunt_phase = PH_LEN_HI;
                    seen_first = 1'b0;
                end else begin
                    seen_first = (b == hdr_first);
                end
            end
            PH_LEN_HI: begin
                len_word   = {b, 8'h00};
                hunt_phase = PH_LEN_LO;
            end
            default: begin
                len_word = {len_word[15:8], b};
                body     = int'(len_word) - 3;
                if (body >= 0 && (body % 4) == 0 &&
                    (body / 4) <= sfd_pkg::MAX_CHANNEL_COUNT) begin
                    chan_total = 6'(body / 4);
                    byte_pos   = '0;
                    hunt_phase = PH_SEQ;
                end else begin
                    bad = 1'b1;
                end
            end
        endcase
        return bad;
    endfunction

    // Advances the predicted parser by one byte; queues results when keep is set.
    task automatic parse_byte(input logic [7:0] b, input bit keep);
        logic [7:0]    lhi;
        logic [7:0]    llo;
        t_frame_result r;
        int            n;
        if (hunt_phase == PH_HUNT || hunt_phase == PH_LEN_HI || hunt_phase == PH_LEN_LO) begin
            if (take_front(b)) begin
                // bad length: drop the first header byte and re-hunt over the other three
                bad_lengths++;
                lhi        = len_word[15:8];
                llo        = len_word[7:0];
                hunt_phase = PH_HUNT;
                seen_first = 1'b0;
                void'(take_front(hdr_second));
                void'(take_front(lhi));
                void'(take_front(llo));
            end
        end else if (hunt_phase == PH_SEQ) begin
            if (byte_pos == 0) begin
                seq_word = {b, 8'h00};
                byte_pos = 8'd1;
            end else begin
                seq_word = {seq_word[15:8], b};
                byte_pos = '0;
                if (chan_total == 0) hunt_phase = PH_TRAIL;
                else                 hunt_phase = PH_DATA;
            end
        end else if (hunt_phase == PH_DATA) begin
            case (byte_pos[1:0])
                2'd0: word_acc = {16'h0000, b};
                2'd1: word_acc[15:8] = b;
                2'd2: word_acc[23:16] = b;
                default: chan_words[byte_pos >> 2] = {b, word_acc};
            endcase
            if (int'(byte_pos) + 1 >= 4 * int'(chan_total)) begin
                hunt_phase = PH_TRAIL;
                byte_pos   = '0;
            end else begin
                byte_pos = byte_pos + 8'd1;
            end
        end else begin
            // trailing byte ignored; the run of results goes out now
            hunt_phase = PH_HUNT;
            seen_first = 1'b0;
            byte_pos   = '0;
            n          = int'(chan_total);
            if (n == sfd_pkg::MAX_CHANNEL_COUNT) full_packets++;
            if (n == 0) begin
                r = '{seq: seq_word, idx: '0, count: '0, bits: '0, last: 1'b1};
                if (keep) pending_results.push_back(r);
            end else begin
                for (int k = 0; k < n; k++) begin
                    r.seq   = seq_word;
                    r.idx   = 5'(k);
                    r.count = 6'(n);
                    r.bits  = chan_words[k];
                    r.last  = (k + 1 == n);
                    if (keep) pending_results.push_back(r);
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Clock, receiver back-pressure, result checker
    // ------------------------------------------------------------------
    initial i_clk = 1'b0;
    always #HALF_PERIOD i_clk = ~i_clk;

    initial m_axis_tready = 1'b0;
    always @(negedge i_clk) begin
        m_axis_tready <= calm || ($urandom_range(0, 99) >= 30);
    end

    always @(posedge i_clk) begin
        t_frame_result want;
        t_frame_result got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.seq   = m_axis_tdata[15:0];
            got.idx   = m_axis_tdata[20:16];
            got.count = m_axis_tdata[26:21];
            got.bits  = m_axis_tdata[58:27];
            got.last  = m_axis_tlast;
            results_seen++;
            if (pending_results.size() == 0) begin
                $error("unexpected result transaction: seq %h idx %0d count %0d bits %h last %b",
                       got.seq, got.idx, got.count, got.bits, got.last);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (got.seq !== want.seq) begin
                    $error("sequence_number: expected %h, actual %h", want.seq, got.seq);
                    mismatch_count++;
                end
                if (got.idx !== want.idx) begin
                    $error("channel_index: expected %0d, actual %0d", want.idx, got.idx);
                    mismatch_count++;
                end
                if (got.count !== want.count) begin
                    $error("channel_count: expected %0d, actual %0d", want.count, got.count);
                    mismatch_count++;
                end
                if (got.bits !== want.bits) begin
                    $error("channel_bits: expected %h, actual %h", want.bits, got.bits);
                    mismatch_count++;
                end
                if (got.last !== want.last) begin
                    $error("last_of_packet: expected %b, actual %b", want.last, got.last);
                    mismatch_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers; all are entered and left at a falling edge
    // ------------------------------------------------------------------

    // One byte transaction. A typed result, if given, replaces the predicted one.
    task automatic send_byte(input logic [7:0] b, input bit has_typed = 1'b0,
                             input t_frame_result typed = '0);
        while (!calm && $urandom_range(0, 99) < 30) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = b;
        do @(posedge i_clk); while (!s_axis_tready);
        parse_byte(b, !has_typed);
        if (has_typed) pending_results.push_back(typed);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    // Wait for the block to drain, then idle for a further SETTLE_CYCLES margin.
    task automatic settle();
        s_axis_tvalid = 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_hdr_reg(input logic [sfd_pkg::CFG_IDX_W-1:0] idx,
                                 input logic [7:0] val);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == sfd_pkg::REG_HDR_FIRST) hdr_first = val;
        else                               hdr_second = val;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Well-formed packet with random sequence number, channel words and trailer.
    task automatic send_packet(input int nch);
        logic [15:0] len;
        len = 16'(3 + 4 * nch);
        send_byte(hdr_first);
        send_byte(hdr_second);
        send_byte(len[15:8]);
        send_byte(len[7:0]);
        repeat (2) send_byte(8'($urandom));
        repeat (4 * nch) send_byte(8'($urandom));
        send_byte(8'($urandom));
        packets_sent++;
    endtask

    // Header followed by a length that fails the 3 + 4k rule.
    task automatic send_bad_length();
        logic [15:0] len;
        int          body;
        case ($urandom_range(0, 7))
            0: len = 16'd0;
            1: len = 16'($urandom_range(1, 2));
            2: len = 16'(3 + 4 * $urandom_range(0, 32) + $urandom_range(1, 3));
            3: len = 16'(3 + 4 * (sfd_pkg::MAX_CHANNEL_COUNT + 1));
            4: len = 16'hFFFF;
            5: len = {hdr_first, hdr_second};   // length bytes look like a header
            default: len = 16'($urandom);
        endcase
        body = int'(len) - 3;
        if (body >= 0 && (body % 4) == 0 && (body / 4) <= sfd_pkg::MAX_CHANNEL_COUNT)
            len = len ^ 16'd1;
        send_byte(hdr_first);
        send_byte(hdr_second);
        send_byte(len[15:8]);
        send_byte(len[7:0]);
    endtask

    // Line noise, leaning toward the first header byte so partial headers show up.
    task automatic send_noise();
        repeat ($urandom_range(1, 6)) begin
            if ($urandom_range(0, 3) == 0) send_byte(hdr_first);
            else                           send_byte(8'($urandom));
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int          target;
        int          pick;
        int          nch;
        logic [7:0]  ph_first;
        logic [7:0]  ph_second;

        // Directed bytes under the reset header. Rows with a typed result close a packet.
        directed_tbl = '{
            // empty packet, sequence 0x1234
            {1'b0, 8'hAA, NO_RESULT}, {1'b0, 8'h55, NO_RESULT},
            {1'b0, 8'h00, NO_RESULT}, {1'b0, 8'h03, NO_RESULT},
            {1'b0, 8'h12, NO_RESULT}, {1'b0, 8'h34, NO_RESULT},
            {1'b1, 8'hFF, {16'h1234, 5'd0, 6'd0, 32'h0000_0000, 1'b1}},
            // length 0xAA55 is bad; resync finds the header hidden in it, then empty packet
            {1'b0, 8'hAA, NO_RESULT}, {1'b0, 8'h55, NO_RESULT},
            {1'b0, 8'hAA, NO_RESULT}, {1'b0, 8'h55, NO_RESULT},
            {1'b0, 8'h00, NO_RESULT}, {1'b0, 8'h03, NO_RESULT},
            {1'b0, 8'hFF, NO_RESULT}, {1'b0, 8'hFF, NO_RESULT},
            {1'b1, 8'h00, {16'hFFFF, 5'd0, 6'd0, 32'h0000_0000, 1'b1}},
            // one channel, all-ones word, sequence zero
            {1'b0, 8'hAA, NO_RESULT}, {1'b0, 8'h55, NO_RESULT},
            {1'b0, 8'h00, NO_RESULT}, {1'b0, 8'h07, NO_RESULT},
            {1'b0, 8'h00, NO_RESULT}, {1'b0, 8'h00, NO_RESULT},
            {1'b0, 8'hFF, NO_RESULT}, {1'b0, 8'hFF, NO_RESULT},
            {1'b0, 8'hFF, NO_RESULT}, {1'b0, 8'hFF, NO_RESULT},
            {1'b1, 8'h00, {16'h0000, 5'd0, 6'd1, 32'hFFFF_FFFF, 1'b1}}
        };

        // predictor reset state
        hdr_first  = sfd_pkg::HDR_FIRST_RST;
        hdr_second = sfd_pkg::HDR_SECOND_RST;
        hunt_phase = PH_HUNT;
        seen_first = 1'b0;
        len_word   = '0;
        byte_pos   = '0;
        seq_word   = '0;
        word_acc   = '0;
        chan_total = '0;
        foreach (chan_words[k]) chan_words[k] = '0;

        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (directed_tbl[i])
            send_byte(directed_tbl[i].rx, directed_tbl[i].has_want, directed_tbl[i].want);

        // Random part: one phase per header setting, extremes included.
        target = bytes_sent;
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin ph_first = 8'hAA; ph_second = 8'h55; end
                1: begin ph_first = 8'h00; ph_second = 8'hFF; end
                2: begin ph_first = 8'hFF; ph_second = 8'h00; end
                3: begin ph_first = 8'h3C; ph_second = 8'h3C; end   // both header bytes equal
                4: begin ph_first = 8'($urandom); ph_second = 8'($urandom); end
                default: begin
                    ph_first  = sfd_pkg::HDR_FIRST_RST;
                    ph_second = sfd_pkg::HDR_SECOND_RST;
                end
            endcase
            settle();
            write_hdr_reg(sfd_pkg::REG_HDR_FIRST, ph_first);
            write_hdr_reg(sfd_pkg::REG_HDR_SECOND, ph_second);
            @(negedge i_clk);

            calm = (phase == 2);   // back-to-back traffic on both sides for one phase
            if (phase == 2) send_packet(sfd_pkg::MAX_CHANNEL_COUNT);

            target = target + RANDOM_BYTES / 6;
            while (bytes_sent < target) begin
                pick = $urandom_range(0, 99);
                if (pick < 70) begin
                    case ($urandom_range(0, 29))
                        0:          nch = sfd_pkg::MAX_CHANNEL_COUNT;
                        1, 2, 3, 4: nch = $urandom_range(5, sfd_pkg::MAX_CHANNEL_COUNT - 1);
                        default:    nch = $urandom_range(0, 4);
                    endcase
                    send_packet(nch);
                end else if (pick < 85) begin
                    send_noise();
                end else begin
                    send_bad_length();
                end
            end
            calm = 1'b0;
        end

        settle();

        $display("Ran %0d bytes over 6 header settings: %0d packets, %0d bad lengths",
                 bytes_sent, packets_sent, bad_lengths);
        $display("Checked %0d results, %0d packets at the full channel count",
                 results_seen, full_packets);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run of this stimulus.
    initial begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
